// ----- rtl/core/perspective_unwarp_address_map_defines.svh -----
// ---------------------------------------------------------------------------
// assertion macros used by the address map top module
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_UNWARP_ADDRESS_MAP_DEFINES_SVH
`define PERSPECTIVE_UNWARP_ADDRESS_MAP_DEFINES_SVH

// implication checked on every clock, ignored during reset
`define PUAM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the following cycle
`define PUAM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/puam_pkg.sv -----
// ---------------------------------------------------------------------------
// puam_pkg
// shared widths and constants of the projective address map
// ---------------------------------------------------------------------------
package puam_pkg;
  localparam int MaxDim    = 4096;
  localparam int DimW      = 13;
  localparam int CoordW    = 12;
  localparam int CoefW     = 32;
  localparam int NumW      = 46;   // a*x + b*y + c, Q16.16
  localparam int DenW      = 46;   // g*x + h*y + 2^30, Q2.30
  localparam int DividW    = 60;   // numerator scaled by 2^14
  localparam int QuoW      = 18;   // quotient bits kept, saturate to 16 beyond
  localparam int NumCells  = QuoW;
  localparam int IdxW      = 24;

  localparam logic [2:0] RegA = 3'd0;
  localparam logic [2:0] RegB = 3'd1;
  localparam logic [2:0] RegC = 3'd2;
  localparam logic [2:0] RegD = 3'd3;
  localparam logic [2:0] RegE = 3'd4;
  localparam logic [2:0] RegF = 3'd5;
  localparam logic [2:0] RegG = 3'd6;
  localparam logic [2:0] RegH = 3'd7;

  // magnitude division token handed between cells
  typedef struct packed {
    logic              vld;
    logic [DividW-1:0] rem_hi;    // partial remainder
    logic [QuoW-1:0]   quo;       // quotient bits so far
    logic              ovf;       // magnitude too big for QuoW bits
  } div_tok_t;

  // side information riding along the chain
  typedef struct packed {
    logic              vld;
    logic              zero_den;
    logic              neg_x;
    logic              neg_y;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
  } side_t;
endpackage

// ----- rtl/core/puam_front.sv -----
// ---------------------------------------------------------------------------
// puam_front
// numerator and denominator products, signs and magnitudes
// ---------------------------------------------------------------------------
module puam_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_vld,
  input  logic [puam_pkg::CoordW-1:0]     x,
  input  logic [puam_pkg::CoordW-1:0]     y,
  input  logic [puam_pkg::DimW-1:0]       w,
  input  logic [puam_pkg::DimW-1:0]       h,
  input  logic signed [puam_pkg::CoefW-1:0] ca, cb, cc, cd, ce, cf, cg, chh,
  output puam_pkg::side_t                 side_o,
  output logic [puam_pkg::DividW-1:0]     magx_o,
  output logic [puam_pkg::DividW-1:0]     magy_o,
  output logic [puam_pkg::DenW-1:0]       magd_o
);
  import puam_pkg::*;

  // stage 1: products
  logic              v1_r;
  logic signed [44:0] pa_r, pb_r, pd_r, pe_r, pg_r, ph_r;
  logic signed [CoefW-1:0] c_r, f_r;
  logic [DimW-1:0]   w1_r, h1_r;
  // stage 2: sums
  logic              v2_r;
  logic signed [NumW-1:0] nx_r, ny_r, dn_r;
  logic [DimW-1:0]   w2_r, h2_r;

  logic signed [12:0] xs, ys;
  assign xs = {1'b0, x};
  assign ys = {1'b0, y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req_vld;
      v2_r <= v1_r;
    end
    pa_r <= 45'(ca) * 45'(xs);
    pb_r <= 45'(cb) * 45'(ys);
    pd_r <= 45'(cd) * 45'(xs);
    pe_r <= 45'(ce) * 45'(ys);
    pg_r <= 45'(cg) * 45'(xs);
    ph_r <= 45'(chh) * 45'(ys);
    c_r  <= cc;
    f_r  <= cf;
    w1_r <= (w > DimW'(MaxDim)) ? DimW'(MaxDim) : w;
    h1_r <= (h > DimW'(MaxDim)) ? DimW'(MaxDim) : h;
    nx_r <= NumW'(pa_r) + NumW'(pb_r) + NumW'(c_r);
    ny_r <= NumW'(pd_r) + NumW'(pe_r) + NumW'(f_r);
    dn_r <= NumW'(pg_r) + NumW'(ph_r) + (NumW'(1) <<< 30);
    w2_r <= w1_r;
    h2_r <= h1_r;
  end

  logic [NumW-1:0] ax, ay, ad;
  assign ax = nx_r[NumW-1] ? NumW'(-nx_r) : NumW'(nx_r);
  assign ay = ny_r[NumW-1] ? NumW'(-ny_r) : NumW'(ny_r);
  assign ad = dn_r[NumW-1] ? NumW'(-dn_r) : NumW'(dn_r);

  assign magx_o = {ax, 14'd0};
  assign magy_o = {ay, 14'd0};
  assign magd_o = ad;
  assign side_o.vld      = v2_r;
  assign side_o.zero_den = (dn_r == '0);
  assign side_o.neg_x    = nx_r[NumW-1] ^ dn_r[NumW-1];
  assign side_o.neg_y    = ny_r[NumW-1] ^ dn_r[NumW-1];
  assign side_o.width    = w2_r;
  assign side_o.height   = h2_r;
endmodule

// ----- rtl/core/puam_div_cell.sv -----
// ---------------------------------------------------------------------------
// puam_div_cell
// one restoring division step for quotient bit k of both coordinates
// ---------------------------------------------------------------------------
module puam_div_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [4:0]                    bit_k,
  input  puam_pkg::div_tok_t            tx_i,
  input  puam_pkg::div_tok_t            ty_i,
  input  logic [puam_pkg::DenW-1:0]     den_i,
  input  puam_pkg::side_t               side_i,
  output puam_pkg::div_tok_t            tx_o,
  output puam_pkg::div_tok_t            ty_o,
  output logic [puam_pkg::DenW-1:0]     den_o,
  output puam_pkg::side_t               side_o
);
  import puam_pkg::*;

  div_tok_t tx_nxt, ty_nxt, tx_r, ty_r;
  logic [DenW-1:0] den_r;
  side_t side_r;

  // rem >= den << k  ?  subtract and set bit k
  function automatic div_tok_t step(div_tok_t t, logic [DenW-1:0] d, logic [4:0] k);
    logic [DividW+QuoW-1:0] sh;
    div_tok_t r;
    sh = ({{(DividW+QuoW-DenW){1'b0}}, d}) << k;
    r = t;
    if ({{QuoW{1'b0}}, t.rem_hi} >= sh) begin
      r.rem_hi = DividW'({{QuoW{1'b0}}, t.rem_hi} - sh);
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    tx_nxt = step(tx_i, den_i, bit_k);
    ty_nxt = step(ty_i, den_i, bit_k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r.vld   <= 1'b0;
      ty_r.vld   <= 1'b0;
      side_r.vld <= 1'b0;
    end else begin
      tx_r.vld   <= tx_i.vld;
      ty_r.vld   <= ty_i.vld;
      side_r.vld <= side_i.vld;
    end
    tx_r.rem_hi <= tx_nxt.rem_hi;
    tx_r.quo    <= tx_nxt.quo;
    tx_r.ovf    <= tx_nxt.ovf;
    ty_r.rem_hi <= ty_nxt.rem_hi;
    ty_r.quo    <= ty_nxt.quo;
    ty_r.ovf    <= ty_nxt.ovf;
    den_r       <= den_i;
    side_r.zero_den <= side_i.zero_den;
    side_r.neg_x    <= side_i.neg_x;
    side_r.neg_y    <= side_i.neg_y;
    side_r.width    <= side_i.width;
    side_r.height   <= side_i.height;
  end

  assign tx_o = tx_r;
  assign ty_o = ty_r;
  assign den_o = den_r;
  assign side_o = side_r;
endmodule

// ----- rtl/core/perspective_unwarp_address_map.sv -----
// ---------------------------------------------------------------------------
// perspective_unwarp_address_map
// projective inverse mapping of an output pixel to a source address
// ---------------------------------------------------------------------------
// One request is taken every clock (busy stays low); its result appears with
// out_valid after two product/sum stages, an overflow check, a chain of 18
// division cells (one quotient bit each for x and y), a saturation stage and
// an index stage. Results cannot be stalled. The user must write coefficients
// through cfg_* while no request is in flight; the block does not enforce it.
module perspective_unwarp_address_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_out_x,
  input  logic [11:0] in_out_y,
  input  logic [12:0] in_src_width,
  input  logic [12:0] in_src_height,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic signed [15:0] out_src_x,
  output logic signed [15:0] out_src_y,
  output logic        out_inside_res,
  output logic [23:0] out_src_index,
  output logic        out_zero_denominator
);
  `include "perspective_unwarp_address_map_defines.svh"
  import puam_pkg::*;

  logic signed [CoefW-1:0] coef_r [8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++)
        coef_r[i] <= (3'(i) == RegA || 3'(i) == RegE) ? 32'sd65536 : 32'sd0;
    end else if (cfg_valid) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  side_t side_f;
  logic [DividW-1:0] mx, my;
  logic [DenW-1:0] md;

  puam_front u_front (
    .clk, .rst_n, .req_vld(start),
    .x(in_out_x), .y(in_out_y), .w(in_src_width), .h(in_src_height),
    .ca(coef_r[RegA]), .cb(coef_r[RegB]), .cc(coef_r[RegC]), .cd(coef_r[RegD]),
    .ce(coef_r[RegE]), .cf(coef_r[RegF]), .cg(coef_r[RegG]), .chh(coef_r[RegH]),
    .side_o(side_f), .magx_o(mx), .magy_o(my), .magd_o(md)
  );

  // overflow check: quotient >= 2^18 iff mag >= den << 18
  div_tok_t tx0_r, ty0_r;
  logic [DenW-1:0] d0_r;
  side_t s0_r;
  logic [DividW+QuoW-1:0] lim;
  assign lim = {{(DividW+QuoW-DenW){1'b0}}, md} << QuoW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx0_r.vld <= 1'b0;
      ty0_r.vld <= 1'b0;
      s0_r.vld  <= 1'b0;
    end else begin
      tx0_r.vld <= side_f.vld;
      ty0_r.vld <= side_f.vld;
      s0_r.vld  <= side_f.vld;
    end
    tx0_r.rem_hi <= mx;
    ty0_r.rem_hi <= my;
    tx0_r.quo    <= '0;
    ty0_r.quo    <= '0;
    tx0_r.ovf    <= ({{QuoW{1'b0}}, mx} >= lim);
    ty0_r.ovf    <= ({{QuoW{1'b0}}, my} >= lim);
    d0_r         <= md;
    s0_r.zero_den <= side_f.zero_den;
    s0_r.neg_x    <= side_f.neg_x;
    s0_r.neg_y    <= side_f.neg_y;
    s0_r.width    <= side_f.width;
    s0_r.height   <= side_f.height;
  end

  div_tok_t        tx_c [NumCells+1];
  div_tok_t        ty_c [NumCells+1];
  logic [DenW-1:0] d_c  [NumCells+1];
  side_t           s_c  [NumCells+1];
  assign tx_c[0] = tx0_r;
  assign ty_c[0] = ty0_r;
  assign d_c[0]  = d0_r;
  assign s_c[0]  = s0_r;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    puam_div_cell u_cell (
      .clk, .rst_n, .bit_k(5'(NumCells-1-k)),
      .tx_i(tx_c[k]), .ty_i(ty_c[k]), .den_i(d_c[k]), .side_i(s_c[k]),
      .tx_o(tx_c[k+1]), .ty_o(ty_c[k+1]), .den_o(d_c[k+1]), .side_o(s_c[k+1])
    );
  end

  div_tok_t tf_x, tf_y;
  side_t sf;
  assign tf_x = tx_c[NumCells];
  assign tf_y = ty_c[NumCells];
  assign sf   = s_c[NumCells];

  function automatic logic signed [15:0] sat(logic ovf, logic [QuoW-1:0] q, logic neg);
    logic big;
    big = ovf || (q > QuoW'(32767));
    if (neg) begin
      if (ovf || q > QuoW'(32768)) return 16'sh8000;
      return 16'(-q);
    end
    if (big) return 16'sh7fff;
    return 16'(q);
  endfunction

  // saturate and range check
  logic        v_s_r, zd_s_r, in_s_r;
  logic signed [15:0] qx_s_r, qy_s_r;
  logic [DimW-1:0] w_s_r;
  logic signed [15:0] qx_n, qy_n;
  assign qx_n = sat(tf_x.ovf, tf_x.quo, sf.neg_x);
  assign qy_n = sat(tf_y.ovf, tf_y.quo, sf.neg_y);

  always_ff @(posedge clk) begin
    if (!rst_n) v_s_r <= 1'b0;
    else        v_s_r <= sf.vld;
    zd_s_r <= sf.zero_den;
    qx_s_r <= sf.zero_den ? 16'sd0 : qx_n;
    qy_s_r <= sf.zero_den ? 16'sd0 : qy_n;
    in_s_r <= !sf.zero_den && !qx_n[15] && !qy_n[15] &&
              (17'(qx_n) < 17'(sf.width)) && (17'(qy_n) < 17'(sf.height));
    w_s_r  <= sf.width;
  end

  // index and output register
  logic [IdxW+DimW-1:0] idx_full;
  assign idx_full = (IdxW+DimW)'(qy_s_r[12:0]) * (IdxW+DimW)'(w_s_r)
                  + (IdxW+DimW)'(qx_s_r[12:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v_s_r;
    out_src_x            <= qx_s_r;
    out_src_y            <= qy_s_r;
    out_inside_res       <= in_s_r;
    out_src_index        <= in_s_r ? idx_full[IdxW-1:0] : '0;
    out_zero_denominator <= zd_s_r;
  end

  `PUAM_ASSERT_NXT(a_out_follows, v_s_r, out_valid, "result lost in last stage")
  `PUAM_ASSERT_IMP(a_zd_not_inside, out_valid && out_zero_denominator,
    !out_inside_res, "zero denominator flagged inside")
  `PUAM_ASSERT_IMP(a_idx_zero, out_valid && !out_inside_res, out_src_index == '0,
    "index nonzero while outside")
  `PUAM_ASSERT_IMP(a_inside_pos, out_valid && out_inside_res,
    !out_src_x[15] && !out_src_y[15], "negative coordinate flagged inside")
endmodule

// ----- test/tb_perspective_unwarp_address_map.sv -----
// ---------------------------------------------------------------------------
// tb_perspective_unwarp_address_map
// writes coefficients, drives output pixel coordinates and frame sizes
// through the projective address map, predicts every result in 64-bit
// integer math and compares
module tb_perspective_unwarp_address_map;
  import puam_pkg::*;

  localparam int LatencyCycles = 23;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } pixel_req_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               in_frame;
    logic [23:0]        idx;
    logic               zden;
  } src_addr_t;

  typedef struct {
    pixel_req_t req;
    logic       known;
    src_addr_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [11:0] in_out_x;
  logic [11:0] in_out_y;
  logic [12:0] in_src_width;
  logic [12:0] in_src_height;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        out_valid;
  logic signed [15:0] out_src_x;
  logic signed [15:0] out_src_y;
  logic        out_inside_res;
  logic [23:0] out_src_index;
  logic        out_zero_denominator;

  perspective_unwarp_address_map uut (.*);

  logic signed [63:0] coef [8];
  src_addr_t          addr_queue [$];
  int                 errors = 0;
  dir_row_t           dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [63:0] sat16(logic signed [63:0] v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic src_addr_t map_pixel(pixel_req_t r);
    logic signed [63:0] x, y, w, h, den, nx, ny, qx, qy;
    src_addr_t o;
    x = r.x;
    y = r.y;
    w = (r.w > MaxDim) ? MaxDim : r.w;
    h = (r.h > MaxDim) ? MaxDim : r.h;
    o = '{default: '0};
    den = coef[RegG] * x + coef[RegH] * y + (64'sd1 <<< 30);
    if (den == 0) begin
      o.zden = 1'b1;
      return o;
    end
    nx = coef[RegA] * x + coef[RegB] * y + coef[RegC];
    ny = coef[RegD] * x + coef[RegE] * y + coef[RegF];
    qx = sat16((nx * 16384) / den);
    qy = sat16((ny * 16384) / den);
    o.sx = qx[15:0];
    o.sy = qy[15:0];
    o.in_frame = qx >= 0 && qy >= 0 && qx < w && qy < h;
    if (o.in_frame) o.idx = 24'(qy * w + qx);
    return o;
  endfunction

  task automatic reset_coefs();
    foreach (coef[i]) coef[i] = 0;
    coef[RegA] = 65536;
    coef[RegE] = 65536;
  endtask

  task automatic write_coef(logic [2:0] ri, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    coef[ri] = $signed(val);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (addr_queue.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
  endtask

  task automatic send_pixel(pixel_req_t r, logic known, src_addr_t res);
    src_addr_t p;
    start         <= 1'b1;
    in_out_x      <= r.x;
    in_out_y      <= r.y;
    in_src_width  <= r.w;
    in_src_height <= r.h;
    do @(posedge clk); while (busy);
    p = map_pixel(r);
    if (known && p != res) begin
      $display("%0t table row disagrees: table %p predicted %p", $time, res, p);
      errors++;
    end
    addr_queue.push_back(p);
  endtask

  task automatic idle_pixel();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // results cannot be held off, so every strobe is checked straight away
  always @(posedge clk) begin
    src_addr_t exp_r;
    if (rst_n && out_valid) begin
      if (addr_queue.size() == 0) begin
        $display("%0t unexpected result", $time);
        errors++;
      end else begin
        exp_r = addr_queue.pop_front();
        if (out_src_x !== exp_r.sx) begin
          $display("%0t src_x exp %0d got %0d", $time, exp_r.sx, out_src_x);
          errors++;
        end
        if (out_src_y !== exp_r.sy) begin
          $display("%0t src_y exp %0d got %0d", $time, exp_r.sy, out_src_y);
          errors++;
        end
        if (out_inside_res !== exp_r.in_frame) begin
          $display("%0t inside exp %0b got %0b", $time, exp_r.in_frame, out_inside_res);
          errors++;
        end
        if (out_src_index !== exp_r.idx) begin
          $display("%0t index exp %0d got %0d", $time, exp_r.idx, out_src_index);
          errors++;
        end
        if (out_zero_denominator !== exp_r.zden) begin
          $display("%0t zero_den exp %0b got %0b", $time, exp_r.zden,
                   out_zero_denominator);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coef(int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< $urandom_range(4, 14);
    endcase
  endfunction

  function automatic pixel_req_t rand_pixel();
    pixel_req_t r;
    r.x = $urandom_range(0, 15) == 0 ? 12'($urandom) : 12'($urandom_range(0, 300));
    r.y = $urandom_range(0, 15) == 0 ? 12'($urandom) : 12'($urandom_range(0, 300));
    case ($urandom_range(0, 7))
      0: r.w = 13'($urandom);
      1: r.w = 13'd0;
      default: r.w = 13'($urandom_range(1, 512));
    endcase
    case ($urandom_range(0, 7))
      0: r.h = 13'($urandom);
      1: r.h = 13'd0;
      default: r.h = 13'($urandom_range(1, 512));
    endcase
    return r;
  endfunction

  task automatic run_burst_phase(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < n) begin
        send_pixel(rand_pixel(), 1'b0, '{default: '0});
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) idle_pixel();
    end
    start <= 1'b0;
  endtask

  initial begin
    src_addr_t none;
    none = '{default: '0};
    rst_n = 1'b0;
    start = 1'b0;
    in_out_x = '0;
    in_out_y = '0;
    in_src_width = '0;
    in_src_height = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_coefs();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients map each pixel onto itself
    dir_rows.push_back('{'{12'd0, 12'd0, 13'd1, 13'd1}, 1'b1,
                         '{16'sd0, 16'sd0, 1'b1, 24'd0, 1'b0}});
    dir_rows.push_back('{'{12'd5, 12'd3, 13'd10, 13'd10}, 1'b1,
                         '{16'sd5, 16'sd3, 1'b1, 24'd35, 1'b0}});
    dir_rows.push_back('{'{12'd4095, 12'd4095, 13'd4096, 13'd4096}, 1'b1,
                         '{16'sd4095, 16'sd4095, 1'b1, 24'd16777215, 1'b0}});
    dir_rows.push_back('{'{12'd4095, 12'd4095, 13'd8191, 13'd8191}, 1'b1,
                         '{16'sd4095, 16'sd4095, 1'b1, 24'd16777215, 1'b0}});
    dir_rows.push_back('{'{12'd7, 12'd2, 13'd0, 13'd0}, 1'b1,
                         '{16'sd7, 16'sd2, 1'b0, 24'd0, 1'b0}});
    dir_rows.push_back('{'{12'd10, 12'd3, 13'd10, 13'd20}, 1'b1,
                         '{16'sd10, 16'sd3, 1'b0, 24'd0, 1'b0}});
    dir_rows.push_back('{'{12'd3, 12'd20, 13'd10, 13'd20}, 1'b1,
                         '{16'sd3, 16'sd20, 1'b0, 24'd0, 1'b0}});
    dir_rows.push_back('{'{12'haaa, 12'h555, 13'h0aaa, 13'h1555}, 1'b0, none});
    dir_rows.push_back('{'{12'h555, 12'haaa, 13'h1555, 13'h0aaa}, 1'b0, none});
    foreach (dir_rows[i]) send_pixel(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
    start <= 1'b0;
    wait_drained();

    // zero denominator: g*1 = -2^30 at x=1
    write_coef(RegG, 32'hc000_0000);
    send_pixel('{12'd1, 12'd0, 13'd100, 13'd100}, 1'b1, '{16'sd0, 16'sd0, 1'b0, 24'd0, 1'b1});
    send_pixel('{12'd2, 12'd9, 13'd100, 13'd100}, 1'b0, none);
    start <= 1'b0;
    wait_drained();
    write_coef(RegG, 32'h0);

    // saturation and negative quotients
    write_coef(RegA, 32'h7fff_ffff);
    write_coef(RegB, 32'h8000_0000);
    write_coef(RegC, 32'hffff_8000);
    write_coef(RegD, 32'h8000_0000);
    write_coef(RegE, 32'h7fff_ffff);
    write_coef(RegF, 32'h0000_4000);
    write_coef(RegH, 32'h7fff_ffff);
    send_pixel('{12'd4095, 12'd0, 13'd50, 13'd50}, 1'b1,
               '{16'sd32767, -16'sd32768, 1'b0, 24'd0, 1'b0});
    send_pixel('{12'd0, 12'd0, 13'd50, 13'd50}, 1'b0, none);
    send_pixel('{12'd0, 12'd4095, 13'd50, 13'd50}, 1'b0, none);
    send_pixel('{12'd4095, 12'd4095, 13'd50, 13'd50}, 1'b0, none);
    start <= 1'b0;
    wait_drained();

    // random phases, each under fresh coefficients
    for (int ph = 0; ph < 9; ph++) begin
      for (int ri = 0; ri < 8; ri++) begin
        if (ri >= 6) write_coef(3'(ri), ph < 2 ? rand_coef(ph) :
                               32'($signed($urandom_range(0, 4095)) - 2048) <<< $urandom_range(4, 18));
        else write_coef(3'(ri), rand_coef(ph < 2 ? ph : $urandom_range(2, 3)));
      end
      run_burst_phase(100);
      wait_drained();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/puam_pkg.sv
rtl/core/puam_front.sv
rtl/core/puam_div_cell.sv
rtl/core/perspective_unwarp_address_map.sv
test/tb_perspective_unwarp_address_map.sv
